[hw/rtl/jnce_pkg.sv]
package jnce_pkg;

    // Sizing
    localparam int PACKET_BYTES     = 64;
    localparam int REPEAT_CHAIN_MAX = 15;
    localparam int PULSE_COUNT_BITS = 32;

    localparam int PKT_CNT_W = 6;
    localparam int RPT_POS_W = 4;

    // Repeat count before saturation: 2-bit multiplier shifted by up to 2*(MAX-1)
    localparam int RPT_SHIFT_W = 2 * REPEAT_CHAIN_MAX;
    localparam int RPT_WIDE_W  = (RPT_SHIFT_W > PULSE_COUNT_BITS) ?
                                 RPT_SHIFT_W : PULSE_COUNT_BITS;

    // Request types
    localparam logic REQ_CMD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Command nibbles
    localparam logic [3:0] CMD_TAP_RESET   = 4'd8;
    localparam logic [3:0] CMD_TAP_RESET_B = 4'd9;
    localparam logic [3:0] CMD_TDO_FLUSH   = 4'd10;
    localparam logic [3:0] CMD_RESERVED    = 4'd11;
    localparam logic [3:0] CMD_REPEAT_BASE = 4'd12;

    // Pattern used by the TAP reset commands: TMS high, TDI low, no capture
    localparam logic [2:0] PAT_TAP_RESET = 3'b010;
    localparam int         TAP_RESET_PULSES = 8;

    typedef struct packed {
        logic       tck_pulse;
        logic       tms_level;
        logic       tdi_level;
        logic       capture_bit;
        logic       byte_valid;
        logic [7:0] tdo_byte;
        logic       packet_end;
        logic       busy_res;
        logic       rejected;
    } t_result;

endpackage

[hw/rtl/jtag_nibble_command_engine.sv]
// JTAG nibble command engine. Items on the input channel are either a
// command nibble (req_type 0) or one TCK tick (req_type 1) carrying the TDO
// level sampled at that tick. Commands 0-7 schedule one pulse (bit 2 =
// capture TDO, bit 1 = TMS, bit 0 = TDI), 8 and 9 schedule eight TMS-high
// pulses, 10 flushes the TDO stream (pads a partial byte, closes the packet),
// 11 is reserved, and 12-15 repeat the previous command (cmd-12) << 2*pos
// times, pos being the position in the repeat chain. Commands that arrive
// while pulses are pending, or a repeat past the chain limit, come back with
// rejected set and change nothing. Every item yields exactly one result item.
// Throughput is one item per clock: the whole state update is a single pass
// of logic from the input ports into the state and result registers, and the
// result register is the only storage between the two channels, so the input
// stalls only while a held result is itself stalled. The result of an accepted item is valid in the next cycle.
module jtag_nibble_command_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_req_type,
    input  logic [3:0] i_cmd_nibble,
    input  logic       i_tdo_level,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_tck_pulse,
    output logic       o_tms_level,
    output logic       o_tdi_level,
    output logic       o_capture_bit,
    output logic       o_byte_valid,
    output logic [7:0] o_tdo_byte,
    output logic       o_packet_end,
    output logic       o_busy_res,
    output logic       o_rejected
);

    localparam int PCB = jnce_pkg::PULSE_COUNT_BITS;
    localparam int WW  = jnce_pkg::RPT_WIDE_W;
    localparam int PW  = jnce_pkg::RPT_POS_W;
    localparam int KW  = jnce_pkg::PKT_CNT_W;

    localparam logic [WW-1:0] PULSE_MAX_W = (WW'(1) << PCB) - WW'(1);

    // Engine state
    logic [PCB-1:0] r_pulses_left,  n_pulses_left;
    logic [2:0]     r_active_pat,   n_active_pat;
    logic [3:0]     r_last_cmd,     n_last_cmd;
    logic [PW-1:0]  r_rpt_pos,      n_rpt_pos;
    logic [7:0]     r_partial_byte, n_partial_byte;
    logic [2:0]     r_bits_in_byte, n_bits_in_byte;
    logic [KW-1:0]  r_bytes_in_pkt, n_bytes_in_pkt;

    // Result register
    logic              r_out_valid;
    jnce_pkg::t_result r_res, n_res;

    logic          in_acc;
    logic [7:0]    byte_or;
    logic [KW:0]   pkt_cnt_inc;
    logic [WW-1:0] rpt_cnt_wide;
    logic [PCB-1:0] rpt_cnt;

    // Hold the input only while a finished result is stalled downstream
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_acc     = i_in_valid & ~o_in_stall;

    assign byte_or     = r_partial_byte | (8'(i_tdo_level) << r_bits_in_byte);
    assign pkt_cnt_inc = {1'b0, r_bytes_in_pkt} + (KW+1)'(1);

    // Repeat count: multiplier of 0..3 times 4^pos, saturated to the counter
    assign rpt_cnt_wide = WW'(i_cmd_nibble - jnce_pkg::CMD_REPEAT_BASE)
                          << {r_rpt_pos, 1'b0};
    assign rpt_cnt = (rpt_cnt_wide > PULSE_MAX_W) ? PULSE_MAX_W[PCB-1:0]
                                                  : rpt_cnt_wide[PCB-1:0];

    always_comb begin
        n_pulses_left  = r_pulses_left;
        n_active_pat   = r_active_pat;
        n_last_cmd     = r_last_cmd;
        n_rpt_pos      = r_rpt_pos;
        n_partial_byte = r_partial_byte;
        n_bits_in_byte = r_bits_in_byte;
        n_bytes_in_pkt = r_bytes_in_pkt;
        n_res          = '0;

        if (i_req_type == jnce_pkg::REQ_TICK) begin
            if (r_pulses_left != '0) begin
                n_res.tck_pulse   = 1'b1;
                n_res.tms_level   = r_active_pat[1];
                n_res.tdi_level   = r_active_pat[0];
                n_res.capture_bit = r_active_pat[2];
                if (r_active_pat[2]) begin
                    if (r_bits_in_byte == 3'd7) begin
                        n_res.byte_valid = 1'b1;
                        n_res.tdo_byte   = byte_or;
                        n_partial_byte   = '0;
                        n_bits_in_byte   = '0;
                        if (pkt_cnt_inc >= (KW+1)'(jnce_pkg::PACKET_BYTES)) begin
                            n_res.packet_end = 1'b1;
                            n_bytes_in_pkt   = '0;
                        end else begin
                            n_bytes_in_pkt = pkt_cnt_inc[KW-1:0];
                        end
                    end else begin
                        n_partial_byte = byte_or;
                        n_bits_in_byte = r_bits_in_byte + 3'd1;
                    end
                end
                n_pulses_left = r_pulses_left - PCB'(1);
            end
        end else if (r_pulses_left != '0) begin
            n_res.rejected = 1'b1;
        end else if (i_cmd_nibble >= jnce_pkg::CMD_REPEAT_BASE) begin
            if (r_rpt_pos >= PW'(jnce_pkg::REPEAT_CHAIN_MAX)) begin
                n_res.rejected = 1'b1;
            end else begin
                n_rpt_pos = r_rpt_pos + PW'(1);
                if (r_last_cmd < jnce_pkg::CMD_TDO_FLUSH) begin
                    n_active_pat  = r_last_cmd[3] ? jnce_pkg::PAT_TAP_RESET
                                                  : r_last_cmd[2:0];
                    n_pulses_left = rpt_cnt;
                end
            end
        end else if (i_cmd_nibble == jnce_pkg::CMD_TDO_FLUSH) begin
            n_rpt_pos = '0;
            if (r_bits_in_byte != '0) begin
                n_res.byte_valid = 1'b1;
                n_res.tdo_byte   = r_partial_byte;
                n_res.packet_end = 1'b1;
                n_partial_byte   = '0;
                n_bits_in_byte   = '0;
                n_bytes_in_pkt   = '0;
            end else if (r_bytes_in_pkt != '0) begin
                n_res.packet_end = 1'b1;
                n_bytes_in_pkt   = '0;
            end
        end else begin
            // 0-9 and reserved 11; TAP reset keeps the repeat position
            n_last_cmd = i_cmd_nibble;
            if (i_cmd_nibble == jnce_pkg::CMD_RESERVED) begin
                n_rpt_pos = '0;
            end else if (i_cmd_nibble[3] == 1'b0) begin
                n_rpt_pos     = '0;
                n_active_pat  = i_cmd_nibble[2:0];
                n_pulses_left = PCB'(1);
            end else begin
                n_active_pat  = jnce_pkg::PAT_TAP_RESET;
                n_pulses_left = PCB'(jnce_pkg::TAP_RESET_PULSES);
            end
        end

        n_res.busy_res = (n_pulses_left != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulses_left  <= '0;
            r_active_pat   <= '0;
            r_last_cmd     <= jnce_pkg::CMD_TAP_RESET;
            r_rpt_pos      <= '0;
            r_partial_byte <= '0;
            r_bits_in_byte <= '0;
            r_bytes_in_pkt <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_out_valid <= in_acc | (r_out_valid & i_out_stall);
            if (in_acc) begin
                r_pulses_left  <= n_pulses_left;
                r_active_pat   <= n_active_pat;
                r_last_cmd     <= n_last_cmd;
                r_rpt_pos      <= n_rpt_pos;
                r_partial_byte <= n_partial_byte;
                r_bits_in_byte <= n_bits_in_byte;
                r_bytes_in_pkt <= n_bytes_in_pkt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tck_pulse   = r_res.tck_pulse;
    assign o_tms_level   = r_res.tms_level;
    assign o_tdi_level   = r_res.tdi_level;
    assign o_capture_bit = r_res.capture_bit;
    assign o_byte_valid  = r_res.byte_valid;
    assign o_tdo_byte    = r_res.tdo_byte;
    assign o_packet_end  = r_res.packet_end;
    assign o_busy_res    = r_res.busy_res;
    assign o_rejected    = r_res.rejected;

    // A refused command never drives a pulse or emits a byte
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |-> !o_tck_pulse && !o_byte_valid && !o_packet_end)
        else $error("rejected result carries activity");

    // Capture only on a driven pulse
    a_capture_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_capture_bit |-> o_tck_pulse)
        else $error("capture without TCK pulse");

    // Busy flag of a held result matches the pulse counter
    a_busy_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_busy_res == (r_pulses_left != '0)))
        else $error("busy flag out of step with pulse counter");

    // Accepted items always show up as a result next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted item produced no result");

endmodule

[tb/jtag_nibble_command_engine_checker.sv]
module jtag_nibble_command_engine_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic       i_req_type,
    input  logic [3:0] i_cmd_nibble,
    input  logic       i_tdo_level,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_tck_pulse,
    input  logic       i_tms_level,
    input  logic       i_tdi_level,
    input  logic       i_capture_bit,
    input  logic       i_byte_valid,
    input  logic [7:0] i_tdo_byte,
    input  logic       i_packet_end,
    input  logic       i_busy_res,
    input  logic       i_rejected,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PCB = jnce_pkg::PULSE_COUNT_BITS;
    localparam logic [63:0] PULSE_MAX = (64'd1 << PCB) - 64'd1;

    // engine state as seen by the predictor
    logic [PCB-1:0]                  pend_pulses;
    logic [2:0]                      cur_pattern;
    logic [3:0]                      last_cmd;
    logic [jnce_pkg::RPT_POS_W-1:0]  chain_pos;
    logic [7:0]                      tdo_acc;
    logic [2:0]                      tdo_nbits;
    logic [jnce_pkg::PKT_CNT_W-1:0]  pkt_bytes;

    jnce_pkg::t_result tdo_results[$];

    task automatic predict_result(input logic rt, input logic [3:0] cmd, input logic tdo,
                                  output jnce_pkg::t_result r);
        logic [63:0] cnt;
        r = '0;
        if (rt == jnce_pkg::REQ_TICK) begin
            if (pend_pulses != '0) begin
                r.tck_pulse   = 1'b1;
                r.tms_level   = cur_pattern[1];
                r.tdi_level   = cur_pattern[0];
                r.capture_bit = cur_pattern[2];
                if (cur_pattern[2]) begin
                    tdo_acc = tdo_acc | (8'(tdo) << tdo_nbits);
                    if (tdo_nbits == 3'd7) begin
                        r.byte_valid = 1'b1;
                        r.tdo_byte   = tdo_acc;
                        tdo_acc      = '0;
                        tdo_nbits    = '0;
                        if (int'(pkt_bytes) + 1 >= jnce_pkg::PACKET_BYTES) begin
                            r.packet_end = 1'b1;
                            pkt_bytes    = '0;
                        end else begin
                            pkt_bytes = pkt_bytes + 1'b1;
                        end
                    end else begin
                        tdo_nbits = tdo_nbits + 1'b1;
                    end
                end
                pend_pulses = pend_pulses - 1'b1;
            end
        end else if (pend_pulses != '0) begin
            r.rejected = 1'b1;
        end else if (cmd >= jnce_pkg::CMD_REPEAT_BASE) begin
            if (chain_pos >= jnce_pkg::REPEAT_CHAIN_MAX) begin
                r.rejected = 1'b1;
            end else begin
                cnt = 64'(cmd - jnce_pkg::CMD_REPEAT_BASE) << (2 * chain_pos);
                if (cnt > PULSE_MAX) cnt = PULSE_MAX;
                chain_pos = chain_pos + 1'b1;
                // a repeat after the reserved command schedules nothing
                if (last_cmd < jnce_pkg::CMD_TDO_FLUSH) begin
                    cur_pattern = (last_cmd < jnce_pkg::CMD_TAP_RESET) ? last_cmd[2:0]
                                                                       : jnce_pkg::PAT_TAP_RESET;
                    pend_pulses = cnt[PCB-1:0];
                end
            end
        end else if (cmd == jnce_pkg::CMD_TDO_FLUSH) begin
            chain_pos = '0;
            if (tdo_nbits != '0) begin
                r.byte_valid = 1'b1;
                r.tdo_byte   = tdo_acc;
                r.packet_end = 1'b1;
                tdo_acc      = '0;
                tdo_nbits    = '0;
                pkt_bytes    = '0;
            end else if (pkt_bytes != '0) begin
                r.packet_end = 1'b1;
                pkt_bytes    = '0;
            end
        end else begin
            // TAP reset keeps the chain position, pattern commands and reserved clear it
            if (cmd < jnce_pkg::CMD_TAP_RESET || cmd == jnce_pkg::CMD_RESERVED) chain_pos = '0;
            last_cmd = cmd;
            if (cmd < jnce_pkg::CMD_TDO_FLUSH) begin
                cur_pattern = (cmd < jnce_pkg::CMD_TAP_RESET) ? cmd[2:0]
                                                              : jnce_pkg::PAT_TAP_RESET;
                pend_pulses = (cmd < jnce_pkg::CMD_TAP_RESET) ?
                              PCB'(1) : PCB'(jnce_pkg::TAP_RESET_PULSES);
            end
        end
        r.busy_res = (pend_pulses != '0);
    endtask

    function automatic int field_diff(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        jnce_pkg::t_result want;
        jnce_pkg::t_result got;
        int                errs;
        errs = 0;
        if (!i_rst_n) begin
            pend_pulses = '0;
            cur_pattern = '0;
            last_cmd    = jnce_pkg::CMD_TAP_RESET;
            chain_pos   = '0;
            tdo_acc     = '0;
            tdo_nbits   = '0;
            pkt_bytes   = '0;
            tdo_results.delete();
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            // results first: an item taken at this edge cannot have its result out yet
            if (i_out_valid && !i_out_stall) begin
                got = {i_tck_pulse, i_tms_level, i_tdi_level, i_capture_bit, i_byte_valid,
                       i_tdo_byte, i_packet_end, i_busy_res, i_rejected};
                if (tdo_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got 0x%0h", $time, got);
                    errs++;
                end else begin
                    want = tdo_results.pop_front();
                    errs += field_diff("tck_pulse", want.tck_pulse, got.tck_pulse);
                    errs += field_diff("tms_level", want.tms_level, got.tms_level);
                    errs += field_diff("tdi_level", want.tdi_level, got.tdi_level);
                    errs += field_diff("capture_bit", want.capture_bit, got.capture_bit);
                    errs += field_diff("byte_valid", want.byte_valid, got.byte_valid);
                    errs += field_diff("tdo_byte", want.tdo_byte, got.tdo_byte);
                    errs += field_diff("packet_end", want.packet_end, got.packet_end);
                    errs += field_diff("busy_res", want.busy_res, got.busy_res);
                    errs += field_diff("rejected", want.rejected, got.rejected);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_result(i_req_type, i_cmd_nibble, i_tdo_level, want);
                tdo_results.push_back(want);
            end
            o_pending <= tdo_results.size();
            if (errs != 0) o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

[tb/jtag_nibble_command_engine_tb.sv]
module jtag_nibble_command_engine_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORK_TARGET = 1450;   // items that actually do something
    localparam int CYCLE_LIMIT = 200000; // watchdog
    localparam int HOLD_AT     = 1000;   // receiver back-pressure burst
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_FROM  = 1800;   // window with no idling on either side
    localparam int QUIET_TO    = 2300;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic       req_type   = jnce_pkg::REQ_CMD;
    logic [3:0] cmd_nibble = '0;
    logic       tdo_level  = 1'b0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic       tck_pulse;
    logic       tms_level;
    logic       tdi_level;
    logic       capture_bit;
    logic       byte_valid;
    logic [7:0] tdo_byte;
    logic       packet_end;
    logic       busy_res;
    logic       rejected;

    int         fail_count;
    int         chk_pending;
    int         cyc = 0;
    logic       quiet;

    // Stimulus-side bookkeeping: only enough of the engine state to keep
    // repeat counts within reach and to know when the pulses are used up.
    longint     pulses_due = 0;
    int         chain_len  = 0;
    logic [3:0] base_cmd   = jnce_pkg::CMD_TAP_RESET;
    int         work_items = 0;
    int         hold_left  = 0;

    assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

    jtag_nibble_command_engine u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_req_type   (req_type),
        .i_cmd_nibble (cmd_nibble),
        .i_tdo_level  (tdo_level),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_tck_pulse  (tck_pulse),
        .o_tms_level  (tms_level),
        .o_tdi_level  (tdi_level),
        .o_capture_bit(capture_bit),
        .o_byte_valid (byte_valid),
        .o_tdo_byte   (tdo_byte),
        .o_packet_end (packet_end),
        .o_busy_res   (busy_res),
        .o_rejected   (rejected)
    );

    jtag_nibble_command_engine_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_req_type   (req_type),
        .i_cmd_nibble (cmd_nibble),
        .i_tdo_level  (tdo_level),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_tck_pulse  (tck_pulse),
        .i_tms_level  (tms_level),
        .i_tdi_level  (tdi_level),
        .i_capture_bit(capture_bit),
        .i_byte_valid (byte_valid),
        .i_tdo_byte   (tdo_byte),
        .i_packet_end (packet_end),
        .i_busy_res   (busy_res),
        .i_rejected   (rejected),
        .o_fail_count (fail_count),
        .o_pending    (chk_pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a correct run finishes far below the limit.
    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off so the engine backs up
    // into its input, and a quiet window where it never stalls.
    always @(posedge clk) begin
        if (cyc == HOLD_AT) hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (quiet) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < 35);
        end
    end

    // Offer one item, with an occasional gap before it, and return at the
    // edge where it is taken. Valid stays high across back-to-back items.
    task automatic send_item(input logic rt, input logic [3:0] cmd, input logic tdo);
        if (!quiet && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rt;
        cmd_nibble <= cmd;
        tdo_level  <= tdo;
        do @(posedge clk); while (in_stall);
    endtask

    // One TCK tick; the unused nibble carries noise.
    task automatic issue_tick(input logic tdo);
        send_item(jnce_pkg::REQ_TICK, 4'($urandom_range(15)), tdo);
        if (pulses_due != 0) begin
            pulses_due--;
            work_items++;
        end
    endtask

    // One command nibble. A repeat whose count would exceed the budget is
    // turned into a zero repeat, which still advances the chain.
    task automatic issue_cmd(input logic [3:0] c, input int budget);
        longint cnt;
        if (pulses_due == 0 && c >= jnce_pkg::CMD_REPEAT_BASE &&
            chain_len < jnce_pkg::REPEAT_CHAIN_MAX &&
            base_cmd < jnce_pkg::CMD_TDO_FLUSH &&
            (longint'(c - jnce_pkg::CMD_REPEAT_BASE) << (2 * chain_len)) > budget) begin
            c = jnce_pkg::CMD_REPEAT_BASE;
        end
        send_item(jnce_pkg::REQ_CMD, c, 1'($urandom));
        // anything sent while pulses remain is refused and changes nothing
        if (pulses_due == 0) begin
            if (c >= jnce_pkg::CMD_REPEAT_BASE) begin
                if (chain_len < jnce_pkg::REPEAT_CHAIN_MAX) begin
                    cnt = longint'(c - jnce_pkg::CMD_REPEAT_BASE) << (2 * chain_len);
                    chain_len++;
                    work_items++;
                    if (base_cmd < jnce_pkg::CMD_TDO_FLUSH) pulses_due = cnt;
                end
            end else if (c == jnce_pkg::CMD_TDO_FLUSH) begin
                chain_len = 0;
                work_items++;
            end else begin
                if (c < jnce_pkg::CMD_TAP_RESET || c == jnce_pkg::CMD_RESERVED) chain_len = 0;
                base_cmd = c;
                work_items++;
                if (c < jnce_pkg::CMD_TAP_RESET) pulses_due = 1;
                else if (c < jnce_pkg::CMD_TDO_FLUSH) pulses_due = jnce_pkg::TAP_RESET_PULSES;
            end
        end
    endtask

    // Tick until the pending pulses are used up, with the odd command
    // thrown in while busy.
    task automatic drain_pulses();
        while (pulses_due != 0) begin
            if ($urandom_range(99) < 4) issue_cmd(4'($urandom_range(15)), 0);
            else issue_tick(1'($urandom));
        end
    endtask

    initial begin
        int   sel;
        int   budget;
        logic bulk_done;
        bulk_done = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        issue_tick(1'b1);                      // idle tick: all zeros, TDO ignored
        issue_cmd(jnce_pkg::CMD_TDO_FLUSH, 0); // flush with nothing to send
        issue_cmd(4'd7, 0);                    // capture, TMS, TDI all high
        issue_tick(1'b1);
        issue_cmd(4'd5, 0);
        issue_tick(1'b0);
        issue_cmd(4'd4, 0);
        issue_tick(1'b1);
        issue_cmd(4'd6, 0);
        issue_tick(1'b1);
        issue_cmd(4'd0, 0);                    // all low, no capture
        issue_tick(1'b1);
        issue_cmd(4'd3, 0);
        issue_tick(1'b0);
        issue_cmd(jnce_pkg::CMD_TAP_RESET_B, 0);
        issue_cmd(jnce_pkg::CMD_RESERVED, 0);  // refused: TAP reset pulses still pending
        repeat (8) issue_tick(1'b1);
        issue_cmd(jnce_pkg::CMD_TDO_FLUSH, 0); // pads the four captured bits, closes packet

        // --- random ---
        while (work_items < WORK_TARGET) begin
            sel = $urandom_range(99);
            if (!bulk_done && work_items > 600) begin
                // exactly 512 captured bits from a clean start: the packet
                // closes on its 64th byte without a flush
                bulk_done = 1'b1;
                issue_cmd(jnce_pkg::CMD_TDO_FLUSH, 0);
                repeat (2) begin
                    issue_cmd(4'd5, 0);
                    drain_pulses();
                    repeat (4) begin
                        issue_cmd(4'd15, 255);
                        drain_pulses();
                    end
                end
            end else if (sel < 40) begin
                issue_cmd(4'($urandom_range(9)), 0);
                drain_pulses();
            end else if (sel < 70) begin
                // base command followed by a chain of repeats
                budget = ($urandom_range(5) == 0) ? 200 : 48;
                issue_cmd(4'($urandom_range(9)), 0);
                drain_pulses();
                repeat ($urandom_range(4, 1)) begin
                    issue_cmd(jnce_pkg::CMD_REPEAT_BASE + 4'($urandom_range(3)), budget);
                    drain_pulses();
                end
            end else if (sel < 78) begin
                issue_cmd(jnce_pkg::CMD_TDO_FLUSH, 0);
            end else if (sel < 83) begin
                // repeats of the reserved command do nothing but advance the
                // chain; the last one runs past the chain limit
                issue_cmd(jnce_pkg::CMD_RESERVED, 0);
                repeat (jnce_pkg::REPEAT_CHAIN_MAX + 1)
                    issue_cmd(jnce_pkg::CMD_REPEAT_BASE + 4'($urandom_range(3)), 0);
            end else if (sel < 88) begin
                issue_cmd(jnce_pkg::CMD_RESERVED, 0);
            end else if (sel < 94) begin
                issue_tick(1'($urandom));
            end else begin
                issue_cmd(4'($urandom_range(15)), 48);
                drain_pulses();
            end
        end

        in_valid <= 1'b0;

        // let every result drain, then a few cycles to catch stray outputs
        do @(posedge clk); while (chk_pending != 0);
        repeat (10) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
